### src/compacting_byte_store_allocator_unit_macros.svh
// Assertion helpers for the byte store allocator.
`ifndef COMPACTING_BYTE_STORE_ALLOCATOR_UNIT_MACROS_SVH
`define COMPACTING_BYTE_STORE_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define CBSA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");
// Next-cycle implication, checked out of reset.
`define CBSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");
`else
`define CBSA_ASSERT_IMPL(label, ante, cons)
`define CBSA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/cbsa_pkg.sv
package cbsa_pkg;

  localparam int HANDLE_W = 9;
  localparam int SLOT_W   = 9;
  localparam int INDEX_W  = 14;
  localparam int ELEN_W   = 15;
  localparam int TLEN_W   = 14;
  localparam int USED_W   = 15;

  typedef enum logic [1:0] {
    OP_SAVE  = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_CLAIM,
    ST_SAVE_RD,
    ST_SAVE_WR,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_MOVE,
    ST_ADJ,
    ST_READ_RD,
    ST_READ_ADDR,
    ST_READ_DATA,
    ST_LEN_RD,
    ST_LEN_CHK
  } state_t;

endpackage

### src/cbsa_ram.sv
module cbsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/compacting_byte_store_allocator_unit.sv
// Steps: a save scans for the lowest free slot on the first byte of an entry,
// then writes the byte; a free moves the tail bytes down, then sweeps the slots.
// Throughput: one item at a time; the byte move and the offset sweep run one
// byte or one slot per cycle through the single-port-pair memories.
// Reset: synchronous active-low; a clearing pass then zeroes every entry of
// the slot table, during which no input transfer is taken.
`include "compacting_byte_store_allocator_unit_macros.svh"

module compacting_byte_store_allocator_unit
  import cbsa_pkg::*;
#(
  parameter int STORE_BYTES = 16384,
  parameter int SLOT_COUNT  = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // data_byte[7:0], slot[16:8], byte_index[30:17], zero[31]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // handle[8:0], read_data[16:9], entry_length[31:17],
                                  // text_length[45:32], used_bytes[60:46], zero[63:61]
  output logic        out_tuser   // dropped
);

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int LW  = $clog2(STORE_BYTES + 1);
  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int CW  = SW + 1;
  localparam int HRW = (SW > HANDLE_W) ? SW : HANDLE_W;
  localparam int MW  = 2 * LW;

  state_t state_r, state_nxt;

  op_t                op_r;
  logic [7:0]         data_r;
  logic               last_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [INDEX_W-1:0] idx_r;
  logic [HRW-1:0]     h_r;
  logic [SW-1:0]      open_r;
  logic               active_r;
  logic [LW-1:0]      fill_r, end_r, base_r, flen_r, src_r, dst_r;
  logic [AW-1:0]      wdst_r;
  logic               mv_pend_r;
  logic [CW-1:0]      cnt_r;
  logic [SW-1:0]      prev_r;
  logic               pend_r;
  logic               rd_hit_r;
  logic [7:0]         rd_r;
  logic               drop_r;

  logic               out_valid_r;
  logic [63:0]        out_data_r;
  logic               out_drop_r;

  // memory ports
  logic          meta_we;
  logic [SW-1:0] meta_waddr, meta_raddr;
  logic [MW-1:0] meta_wdata, meta_rdata;
  logic          byte_we;
  logic [AW-1:0] byte_waddr, byte_raddr;
  logic [7:0]    byte_wdata, byte_rdata;

  cbsa_ram #(.WIDTH(MW), .DEPTH(SLOT_COUNT)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  cbsa_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_bytes (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (byte_wdata),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

  // decoded helpers
  logic          slot_ok, slot_in_range, h_ok, cnt_live, out_free, store_room, mv_live;
  logic [SW-1:0] slot_idx, h_idx;
  logic [LW-1:0] meta_off, meta_size, base_c, avail_c, flen_c, adj_off, len_c;
  logic [MW-1:0] adj_wdata;
  logic [31:0]   rsum;
  logic [LW-1:0] off_sel;

  always_comb begin
    slot_in_range = 32'(slot_r) < SLOT_COUNT;
    slot_ok       = (slot_r != '0) && slot_in_range;
    slot_idx      = SW'(slot_r);
    h_ok          = (h_r != '0) && (32'(h_r) < SLOT_COUNT);
    h_idx         = SW'(h_r);
    cnt_live      = cnt_r < CW'(SLOT_COUNT);
    out_free      = !out_valid_r || out_tready;
    store_room    = fill_r < LW'(STORE_BYTES);
    mv_live       = src_r < end_r;
    meta_off      = meta_rdata[LW-1:0];
    meta_size     = meta_rdata[MW-1:LW];
    // clamp the freed span to the filled part of the store
    base_c        = (meta_off > fill_r) ? fill_r : meta_off;
    avail_c       = fill_r - base_c;
    flen_c        = (meta_size > avail_c) ? avail_c : meta_size;
    // lower offsets that lie above the freed span
    if (meta_off > base_r) begin
      adj_off = (meta_off >= flen_r) ? (meta_off - flen_r) : '0;
    end else begin
      adj_off = meta_off;
    end
    adj_wdata     = (prev_r == slot_idx) ? '0 : {meta_size, adj_off};
    off_sel       = slot_in_range ? meta_off : '0;
    rsum          = 32'(off_sel) + 32'(idx_r);
    len_c         = h_ok ? meta_size : '0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:     if (cnt_r == CW'(SLOT_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE:      if (in_tvalid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        case (op_r)
          OP_SAVE:  state_nxt = active_r ? ST_SAVE_RD : ST_SCAN;
          OP_FREE:  state_nxt = slot_ok ? ST_FREE_RD : ST_LEN_RD;
          OP_READ:  state_nxt = ST_READ_RD;
          default:  state_nxt = ST_LEN_RD;
        endcase
      end
      ST_SCAN: begin
        if (pend_r && meta_rdata == '0) begin
          state_nxt = ST_CLAIM;
        end else if (!pend_r && !cnt_live) begin
          state_nxt = ST_SAVE_RD;
        end
      end
      ST_CLAIM:     state_nxt = ST_SAVE_RD;
      ST_SAVE_RD:   state_nxt = (h_ok && store_room) ? ST_SAVE_WR : ST_LEN_RD;
      ST_SAVE_WR:   state_nxt = ST_LEN_RD;
      ST_FREE_RD:   state_nxt = ST_FREE_CHK;
      ST_FREE_CHK:  state_nxt = ST_MOVE;
      ST_MOVE:      if (!mv_live && !mv_pend_r) state_nxt = ST_ADJ;
      ST_ADJ:       if (!cnt_live && !pend_r) state_nxt = ST_LEN_RD;
      ST_READ_RD:   state_nxt = ST_READ_ADDR;
      ST_READ_ADDR: state_nxt = ST_READ_DATA;
      ST_READ_DATA: state_nxt = ST_LEN_RD;
      ST_LEN_RD:    state_nxt = ST_LEN_CHK;
      ST_LEN_CHK:   if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_CLEAR;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    meta_we    = 1'b0;
    meta_waddr = prev_r;
    meta_wdata = '0;
    meta_raddr = h_idx;
    byte_we    = 1'b0;
    byte_waddr = wdst_r;
    byte_wdata = byte_rdata;
    byte_raddr = src_r[AW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = cnt_r[SW-1:0];
      end
      ST_SCAN:    meta_raddr = cnt_r[SW-1:0];
      ST_CLAIM: begin
        meta_we    = 1'b1;
        meta_waddr = h_idx;
        meta_wdata = {{LW{1'b0}}, fill_r};
      end
      ST_SAVE_WR: begin
        meta_we    = 1'b1;
        meta_waddr = h_idx;
        meta_wdata = {meta_size + LW'(1), meta_off};
        byte_we    = 1'b1;
        byte_waddr = fill_r[AW-1:0];
        byte_wdata = data_r;
      end
      ST_FREE_RD: meta_raddr = slot_idx;
      ST_MOVE:    byte_we = mv_pend_r;
      ST_ADJ: begin
        meta_raddr = cnt_r[SW-1:0];
        meta_we    = pend_r;
        meta_wdata = adj_wdata;
      end
      ST_READ_RD:   meta_raddr = slot_idx;
      ST_READ_ADDR: byte_raddr = AW'(rsum);
      default: begin
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      active_r    <= 1'b0;
      open_r      <= '0;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      mv_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // load the result register, or drop it once transferred
      if (state_r == ST_LEN_CHK && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: cnt_r <= cnt_r + CW'(1);
        ST_IDLE: begin
          if (in_tvalid) begin
            op_r   <= op_t'(in_tuser);
            data_r <= in_tdata[7:0];
            slot_r <= in_tdata[16:8];
            idx_r  <= in_tdata[30:17];
            last_r <= in_tlast;
          end
        end
        ST_DISPATCH: begin
          rd_r   <= '0;
          drop_r <= 1'b0;
          if (op_r == OP_SAVE) begin
            h_r    <= HRW'(open_r);
            cnt_r  <= CW'(1);
            pend_r <= 1'b0;
          end else begin
            h_r    <= HRW'(slot_r);
          end
        end
        // search for the lowest free slot, one read per cycle
        ST_SCAN: begin
          pend_r <= cnt_live;
          prev_r <= cnt_r[SW-1:0];
          if (cnt_live) begin
            cnt_r <= cnt_r + CW'(1);
          end
          if (pend_r && meta_rdata == '0) begin
            h_r      <= HRW'(prev_r);
            open_r   <= prev_r;
            active_r <= 1'b1;
          end else if (!pend_r && !cnt_live) begin
            h_r      <= '0;
            open_r   <= '0;
            active_r <= 1'b1;
          end
        end
        ST_SAVE_RD: begin
          if (!(h_ok && store_room)) begin
            drop_r <= 1'b1;
            if (last_r) begin
              active_r <= 1'b0;
              open_r   <= '0;
            end
          end
        end
        ST_SAVE_WR: begin
          fill_r <= fill_r + LW'(1);
          if (last_r) begin
            active_r <= 1'b0;
            open_r   <= '0;
          end
        end
        ST_FREE_CHK: begin
          base_r    <= base_c;
          flen_r    <= flen_c;
          src_r     <= base_c + flen_c;
          dst_r     <= base_c;
          end_r     <= fill_r;
          mv_pend_r <= 1'b0;
          if (active_r && open_r == slot_idx) begin
            open_r <= '0;
          end
        end
        // move the tail down over the gap, read ahead of write
        ST_MOVE: begin
          mv_pend_r <= mv_live;
          wdst_r    <= dst_r[AW-1:0];
          if (mv_live) begin
            src_r <= src_r + LW'(1);
            dst_r <= dst_r + LW'(1);
          end else if (!mv_pend_r) begin
            fill_r <= fill_r - flen_r;
            cnt_r  <= '0;
            pend_r <= 1'b0;
          end
        end
        // sweep the slot table, clear the freed slot and lower offsets above the gap
        ST_ADJ: begin
          pend_r <= cnt_live;
          prev_r <= cnt_r[SW-1:0];
          if (cnt_live) begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        ST_READ_ADDR: rd_hit_r <= rsum < 32'(fill_r);
        ST_READ_DATA: rd_r <= rd_hit_r ? byte_rdata : 8'd0;
        ST_LEN_CHK: begin
          if (out_free) begin
            out_data_r  <= {3'd0,
                            USED_W'(fill_r),
                            (len_c != '0) ? TLEN_W'(len_c - LW'(1)) : TLEN_W'(0),
                            ELEN_W'(len_c),
                            rd_r,
                            HANDLE_W'(h_r)};
            out_drop_r  <= drop_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_drop_r;

  `CBSA_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, !in_tready)
  `CBSA_ASSERT_IMPL(a_move_span, state_r == ST_MOVE, dst_r + flen_r == src_r)
  `CBSA_ASSERT_IMPL(a_fill_cap, state_r == ST_SAVE_WR, fill_r < LW'(STORE_BYTES))

endmodule

### test/cbsa_result_checker.sv
module cbsa_result_checker
  import cbsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_BYTES = 16384;
  localparam int SLOT_COUNT  = 512;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [7:0]          read_data;
    logic [ELEN_W-1:0]   entry_length;
    logic [TLEN_W-1:0]   text_length;
    logic [USED_W-1:0]   used_bytes;
    logic                dropped;
  } alloc_result_t;

  // Shadow copy of the store and slot table
  bit [7:0] store_mem [STORE_BYTES];
  int       slot_base [SLOT_COUNT];
  int       slot_len  [SLOT_COUNT];
  int       fill;
  int       open_slot;
  bit       saving;

  alloc_result_t expected_results [$];

  function automatic int lowest_free_slot();
    for (int i = 1; i < SLOT_COUNT; i++)
      if (slot_base[i] == 0 && slot_len[i] == 0) return i;
    return 0;
  endfunction

  // Close the gap left by a freed entry and pull later offsets down
  function automatic void compact_out(int s);
    int base;
    int len;
    int tail;
    if (s == 0 || s >= SLOT_COUNT) return;
    base = slot_base[s];
    len  = slot_len[s];
    if (base > fill) base = fill;
    if (len > fill - base) len = fill - base;
    tail = base + len;
    if (len != 0)
      for (int i = 0; i < fill - tail; i++) store_mem[base + i] = store_mem[tail + i];
    fill -= len;
    slot_base[s] = 0;
    slot_len[s]  = 0;
    for (int i = 0; i < SLOT_COUNT; i++)
      if (slot_base[i] > base) slot_base[i] = (slot_base[i] >= len) ? slot_base[i] - len : 0;
    if (saving && open_slot == s) open_slot = 0;
  endfunction

  function automatic alloc_result_t predict_result(op_t op, logic [7:0] data, logic last,
                                                   int s, int idx);
    alloc_result_t r;
    int h;
    int len;
    int addr;
    h = s;
    r = '0;
    case (op)
      OP_SAVE: begin
        if (!saving) begin
          open_slot = lowest_free_slot();
          if (open_slot != 0) begin
            slot_base[open_slot] = fill;
            slot_len[open_slot]  = 0;
          end
          saving = 1;
        end
        h = open_slot;
        if (h != 0 && fill < STORE_BYTES) begin
          store_mem[fill] = data;
          fill++;
          slot_len[h]++;
        end else begin
          r.dropped = 1'b1;
        end
        if (last) begin
          saving    = 0;
          open_slot = 0;
        end
      end
      OP_FREE: compact_out(s);
      OP_READ: begin
        addr = slot_base[s] + idx;
        if (addr < fill && addr < STORE_BYTES) r.read_data = store_mem[addr];
      end
      default: ;
    endcase
    len = (h != 0) ? slot_len[h] : 0;
    r.handle       = HANDLE_W'(h);
    r.entry_length = ELEN_W'(len);
    r.text_length  = TLEN_W'(len ? len - 1 : 0);
    r.used_bytes   = USED_W'(fill);
    return r;
  endfunction

  assign pending = expected_results.size();

  // Clear the shadow state in reset; predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    alloc_result_t exp_r;
    alloc_result_t got;
    if (!rst_n) begin
      fail_count = 0;
      fill       = 0;
      open_slot  = 0;
      saving     = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_base[i] = 0;
        slot_len[i]  = 0;
      end
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_result(op_t'(in_tuser), in_tdata[7:0], in_tlast,
                                                  int'(in_tdata[16:8]), int'(in_tdata[30:17])));
      if (out_tvalid && out_tready) begin
        got.handle       = out_tdata[8:0];
        got.read_data    = out_tdata[16:9];
        got.entry_length = out_tdata[31:17];
        got.text_length  = out_tdata[45:32];
        got.used_bytes   = out_tdata[60:46];
        got.dropped      = out_tuser;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.handle !== exp_r.handle || got.read_data !== exp_r.read_data ||
              got.entry_length !== exp_r.entry_length ||
              got.text_length !== exp_r.text_length ||
              got.used_bytes !== exp_r.used_bytes || got.dropped !== exp_r.dropped) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
          end
        end
      end
    end
  end
endmodule

### test/tb_compacting_byte_store_allocator_unit.sv
module tb_compacting_byte_store_allocator_unit;
  import cbsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          calm;

  compacting_byte_store_allocator_unit i_dut (.*);

  cbsa_result_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Stall the result channel a random number of cycles before each transfer
  initial begin
    int k;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      k = draw_gap();
      @(negedge clk);
      if (k > 0) begin
        out_tready <= 0;
        repeat (k - 1) @(negedge clk);
        @(negedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Push one item through the input channel
  task automatic put_item(op_t op, logic [7:0] data, logic last, logic [8:0] s,
                          logic [13:0] idx);
    int k;
    k = draw_gap();
    if (k > 0) begin
      in_tvalid <= 0;
      repeat (k) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tlast  <= last;
    in_tdata  <= {1'b0, idx, s, data};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic save_entry(int nbytes);
    for (int i = 0; i < nbytes; i++)
      put_item(OP_SAVE, 8'($urandom_range(0, 255)), i == nbytes - 1, 9'($urandom),
               14'($urandom));
  endtask

  initial begin
    int n;
    int kind;
    rst_n     = 0;
    in_tvalid = 0;
    in_tdata  = '0;
    in_tuser  = OP_SAVE;
    in_tlast  = 0;
    calm      = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: field extremes and the special cases
    put_item(OP_SAVE, 8'h00, 0, 9'd0, 14'd0);
    put_item(OP_SAVE, 8'hFF, 0, 9'd511, 14'h3FFF);
    put_item(OP_SAVE, 8'h5A, 1, 9'd0, 14'd0);
    put_item(OP_SAVE, 8'hA5, 0, 9'd0, 14'd0);
    put_item(OP_SAVE, 8'h3C, 1, 9'd0, 14'd0);
    for (int i = 0; i < 3; i++) put_item(OP_READ, 8'hFF, 1, 9'd1, 14'(i));
    put_item(OP_READ, 8'h00, 0, 9'd1, 14'h3FFF);
    put_item(OP_READ, 8'h00, 0, 9'd511, 14'd0);
    put_item(OP_READ, 8'h00, 0, 9'd0, 14'd4);
    put_item(OP_QUERY, 8'h00, 0, 9'd1, 14'd0);
    put_item(OP_QUERY, 8'h00, 0, 9'd0, 14'd0);
    put_item(OP_QUERY, 8'h00, 0, 9'd511, 14'd0);
    put_item(OP_FREE, 8'h00, 0, 9'd0, 14'd0);
    put_item(OP_FREE, 8'h00, 0, 9'd511, 14'd0);
    // free the entry while it is being saved
    put_item(OP_SAVE, 8'h11, 0, 9'd0, 14'd0);
    put_item(OP_FREE, 8'h00, 0, 9'd3, 14'd0);
    put_item(OP_SAVE, 8'h22, 0, 9'd0, 14'd0);
    put_item(OP_SAVE, 8'h33, 1, 9'd0, 14'd0);
    // free the first entry so the second one moves down
    put_item(OP_FREE, 8'h00, 0, 9'd1, 14'd0);
    put_item(OP_READ, 8'h00, 0, 9'd2, 14'd1);
    put_item(OP_QUERY, 8'h00, 0, 9'd2, 14'd0);

    // Random: mostly whole entries with frees, reads and queries mixed in
    n = 0;
    while (n < 75) begin
      if (n % 32 == 16) calm = ~calm;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        save_entry($urandom_range(1, 5));
        n += 3;
      end else begin
        if (kind < 55)
          put_item(OP_FREE, 8'($urandom), 1'($urandom),
                   9'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 9)),
                   14'($urandom));
        else if (kind < 75)
          put_item(OP_READ, 8'($urandom), 1'($urandom),
                   9'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 9)),
                   14'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 7)));
        else if (kind < 90)
          put_item(OP_QUERY, 8'($urandom), 1'($urandom), 9'($urandom_range(0, 9)),
                   14'($urandom));
        else
          put_item(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 9'($urandom),
                   14'($urandom));
        n++;
      end
    end
    calm = 0;

    // Reads and a save around a freed slot
    put_item(OP_READ, 8'h00, 0, 9'd495, 14'h3FFF);
    put_item(OP_QUERY, 8'h00, 0, 9'd500, 14'd0);
    put_item(OP_FREE, 8'h00, 0, 9'd1, 14'd0);
    save_entry(3);
    put_item(OP_READ, 8'h00, 0, 9'd0, 14'h3FFF);
    in_tvalid <= 0;

    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

### filelist.f
+incdir+src
src/cbsa_pkg.sv
src/cbsa_ram.sv
src/compacting_byte_store_allocator_unit.sv
test/cbsa_result_checker.sv
test/tb_compacting_byte_store_allocator_unit.sv
